### rtl/core/sdfa_pkg.sv
// ============================================================================
// SPH density and pressure force accumulator - shared definitions
// Step codes, controller/datapath bundles and fixed constants.
// ============================================================================
package sdfa_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DENS_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_COEF = 3'd4;

    localparam logic [63:0] LIMIT      = 64'h4000_0000_0000_0000;
    localparam logic [30:0] MASK31     = 31'h7fff_ffff;
    localparam logic [63:0] FULL_SCALE = 64'h0000_0000_8000_0000;

    typedef enum logic [4:0] {
        OP_SQX, OP_SQY, OP_SQR,
        OP_D1, OP_D2, OP_D3, OP_DACC,
        OP_ROOT, OP_F, OP_GM, OP_P1, OP_P2, OP_R1, OP_R2, OP_M1, OP_M2,
        OP_UX, OP_MX, OP_FXACC, OP_UY, OP_MY, OP_FYACC,
        OP_FIN
    } op_t;

    typedef struct packed {
        logic load;
        logic start;
        logic emit;
        op_t  op;
    } ctl_cmd_t;

    typedef struct packed {
        logic done;
        logic kind;
        logic last;
        logic dens_skip;
        logic force_skip;
        logic out_free;
    } ctl_sts_t;

endpackage

### rtl/core/sdfa_mul.sv
// ============================================================================
// SPH accumulator - sequential 64x64 multiplier
// Four 32x32 partial products, one per cycle, summed into a 128-bit product.
// ============================================================================
module sdfa_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  opa, opb;
    logic [63:0]  pp_next;
    logic [127:0] pp_shifted;

    assign opa        = a_reg[{step_reg[1], 5'd0} +: 32];
    assign opb        = b_reg[{step_reg[0], 5'd0} +: 32];
    assign pp_next    = opa * opb;
    assign pp_shifted = {64'd0, pp_reg} << {sh_reg, 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (step_reg == 3'd4);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (step_reg != 3'd4) begin
                pp_reg <= pp_next;
                sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

### rtl/core/sdfa_div.sv
// ============================================================================
// SPH accumulator - restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ============================================================================
module sdfa_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [63:0] quo,
    output logic        done
);
    logic [63:0] num_reg;
    logic [31:0] rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] rem_sh, rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= 32'd0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[62:0], ge};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;
endmodule

### rtl/core/sdfa_sqrt.sv
// ============================================================================
// SPH accumulator - integer square root
// Digit-by-digit floor square root of a 64-bit value, one digit per cycle.
// ============================================================================
module sdfa_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] v,
    output logic [31:0] root,
    output logic        done
);
    logic [63:0] val_reg, res_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;
    logic        ge;

    assign trial = res_reg + bit_reg;
    assign ge    = val_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg <= v;
            res_reg <= 64'd0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (ge) begin
                val_reg <= val_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[31:0];
    assign done = done_reg;
endmodule

### rtl/core/sdfa_datapath.sv
// ============================================================================
// SPH accumulator - datapath
// Pair registers, shared arithmetic units, accumulators and output register.
// ============================================================================
module sdfa_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sdfa_pkg::ctl_cmd_t            cmd,
    output sdfa_pkg::ctl_sts_t            sts,
    input  logic                          cfg_wr_en,
    input  logic [sdfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic [127:0]                  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,
    output logic                          m_tuser
);
    localparam logic [30:0] MIN_RADIUS = 31'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [63:0] RECIP_NUM  = 64'd1 << (2 * FRAC_BITS);

    logic [30:0] sr_reg, rest_reg, gain_reg, coef_reg;
    logic [31:0] gc_reg;

    logic        kind_reg, last_reg, xneg_reg, yneg_reg;
    logic [31:0] ax_reg, ay_reg;
    logic [30:0] own_reg, nb_reg;
    logic [63:0] r2_reg, sr2_reg, t_reg, f_reg, gm_reg, pm1_reg, pm2_reg;
    logic        p1neg_reg, p2neg_reg;
    logic [63:0] rec1_reg, rec2_reg, m1_reg, m2_reg, u_reg, mag_reg;
    logic [31:0] r_reg;
    logic        item_ov_reg;

    logic [30:0] dens_reg;
    logic [31:0] fx_reg, fy_reg;
    logic        sat_reg;
    logic        out_valid_reg;
    logic [30:0] dens_out_reg;
    logic [31:0] fx_out_reg, fy_out_reg;
    logic        sat_out_reg;
    logic        none_done_reg;

    logic        is_mul, is_div, is_sqrt, is_none;
    logic [63:0] mul_a, mul_b, div_num;
    logic [31:0] div_den;
    logic [127:0] mul_prod;
    logic [63:0] div_quo;
    logic [31:0] sq_root;
    logic        mul_done, div_done, sqrt_done, step_done;

    logic [30:0] sr_eff;
    logic [63:0] d_val;
    logic [31:0] s_val, e1, e2, e1_mag, e2_mag, gc_mag;
    logic [127:0] qfull;
    logic        qov;
    logic [63:0] qval;
    logic signed [65:0] s1, s2, psum, psum_abs;
    logic        sneg, gneg;
    logic [63:0] shm, rsum, mag_ov;
    logic        t_big;
    logic [30:0] t_clip;
    logic [31:0] dsum;
    logic        acc_neg;
    logic signed [65:0] acc_val, acc_base, acc_sum;
    logic [31:0] acc_clip;
    logic        acc_sat;

    // Step decode.
    always_comb begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        is_none = 1'b0;
        case (cmd.op)
            sdfa_pkg::OP_R1, sdfa_pkg::OP_R2, sdfa_pkg::OP_UX, sdfa_pkg::OP_UY: begin
                is_div = 1'b1;
            end
            sdfa_pkg::OP_ROOT: begin
                is_sqrt = 1'b1;
            end
            sdfa_pkg::OP_DACC, sdfa_pkg::OP_FXACC, sdfa_pkg::OP_FYACC,
            sdfa_pkg::OP_FIN: begin
                is_none = 1'b1;
            end
            default: begin
                is_mul = 1'b1;
            end
        endcase
    end

    assign sr_eff = kind_reg ? sr_reg : ((sr_reg < MIN_RADIUS) ? MIN_RADIUS : sr_reg);
    assign d_val  = (sr2_reg - r2_reg) >> FRAC_BITS;
    assign s_val  = {1'b0, sr_reg} - r_reg;
    assign e1     = {1'b0, own_reg} - {1'b0, rest_reg};
    assign e2     = {1'b0, nb_reg} - {1'b0, rest_reg};
    assign e1_mag = e1[31] ? (~e1 + 32'd1) : e1;
    assign e2_mag = e2[31] ? (~e2 + 32'd1) : e2;
    assign gc_mag = gc_reg[31] ? (~gc_reg + 32'd1) : gc_reg;
    assign gneg   = gc_reg[31];

    assign s1       = p1neg_reg ? -$signed({2'b00, pm1_reg}) : $signed({2'b00, pm1_reg});
    assign s2       = p2neg_reg ? -$signed({2'b00, pm2_reg}) : $signed({2'b00, pm2_reg});
    assign psum     = s1 + s2;
    assign sneg     = psum[65];
    assign psum_abs = sneg ? -psum : psum;
    assign shm      = psum_abs[64:1];
    assign rsum     = rec1_reg + rec2_reg;
    assign mag_ov   = (shm != 64'd0 && gm_reg != 64'd0 && u_reg != 64'd0)
                      ? sdfa_pkg::FULL_SCALE : 64'd0;

    assign qfull = mul_prod >> FRAC_BITS;
    assign qov   = qfull > {64'd0, sdfa_pkg::LIMIT};
    assign qval  = qov ? sdfa_pkg::LIMIT : qfull[63:0];

    always_comb begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        case (cmd.op)
            sdfa_pkg::OP_SQX: begin
                mul_a = {32'd0, ax_reg};
                mul_b = {32'd0, ax_reg};
            end
            sdfa_pkg::OP_SQY: begin
                mul_a = {32'd0, ay_reg};
                mul_b = {32'd0, ay_reg};
            end
            sdfa_pkg::OP_SQR: begin
                mul_a = {33'd0, sr_eff};
                mul_b = {33'd0, sr_eff};
            end
            sdfa_pkg::OP_D1: begin
                mul_a = {33'd0, coef_reg};
                mul_b = d_val;
            end
            sdfa_pkg::OP_D2, sdfa_pkg::OP_D3: begin
                mul_a = t_reg;
                mul_b = d_val;
            end
            sdfa_pkg::OP_F: begin
                mul_a = {32'd0, s_val};
                mul_b = {32'd0, s_val};
            end
            sdfa_pkg::OP_GM: begin
                mul_a = {32'd0, gc_mag};
                mul_b = f_reg;
            end
            sdfa_pkg::OP_P1: begin
                mul_a = {32'd0, e1_mag};
                mul_b = {33'd0, gain_reg};
            end
            sdfa_pkg::OP_P2: begin
                mul_a = {32'd0, e2_mag};
                mul_b = {33'd0, gain_reg};
            end
            sdfa_pkg::OP_M1: begin
                mul_a = shm;
                mul_b = rsum;
            end
            sdfa_pkg::OP_M2: begin
                mul_a = m1_reg;
                mul_b = gm_reg;
            end
            sdfa_pkg::OP_MX, sdfa_pkg::OP_MY: begin
                mul_a = m2_reg;
                mul_b = u_reg;
            end
            default: begin
                mul_a = 64'd0;
                mul_b = 64'd0;
            end
        endcase
    end

    always_comb begin
        div_num = RECIP_NUM;
        div_den = r_reg;
        case (cmd.op)
            sdfa_pkg::OP_R1: begin
                div_den = {1'b0, own_reg};
            end
            sdfa_pkg::OP_R2: begin
                div_den = {1'b0, nb_reg};
            end
            sdfa_pkg::OP_UX: begin
                div_num = {32'd0, ax_reg} << FRAC_BITS;
            end
            sdfa_pkg::OP_UY: begin
                div_num = {32'd0, ay_reg} << FRAC_BITS;
            end
            default: begin
                div_num = RECIP_NUM;
            end
        endcase
    end

    sdfa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && is_mul),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    sdfa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && is_div),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    sdfa_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && is_sqrt),
        .v       (r2_reg),
        .root    (sq_root),
        .done    (sqrt_done)
    );

    assign step_done = mul_done || div_done || sqrt_done || none_done_reg;

    // Accumulator updates.
    assign t_big  = t_reg > {33'd0, sdfa_pkg::MASK31};
    assign t_clip = (item_ov_reg || t_big) ? sdfa_pkg::MASK31 : t_reg[30:0];
    assign dsum   = {1'b0, dens_reg} + {1'b0, t_clip};

    assign acc_neg  = ~(sneg ^ gneg ^ ((cmd.op == sdfa_pkg::OP_FYACC) ? yneg_reg : xneg_reg));
    assign acc_val  = acc_neg ? -$signed({2'b00, mag_reg}) : $signed({2'b00, mag_reg});
    assign acc_base = (cmd.op == sdfa_pkg::OP_FYACC)
                      ? 66'(signed'(fy_reg)) : 66'(signed'(fx_reg));
    assign acc_sum  = acc_base + acc_val;

    always_comb begin
        acc_sat  = 1'b0;
        acc_clip = acc_sum[31:0];
        if (acc_sum > 66'sd2147483647) begin
            acc_sat  = 1'b1;
            acc_clip = 32'h7fff_ffff;
        end else if (acc_sum < -66'sd2147483648) begin
            acc_sat  = 1'b1;
            acc_clip = 32'h8000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg        <= 31'd32768;
            rest_reg      <= 31'd131072;
            gain_reg      <= 31'd655360;
            coef_reg      <= 31'd0;
            gc_reg        <= 32'd0;
            dens_reg      <= 31'd0;
            fx_reg        <= 32'd0;
            fy_reg        <= 32'd0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            none_done_reg <= 1'b0;
            item_ov_reg   <= 1'b0;
        end else begin
            none_done_reg <= cmd.start && is_none;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sdfa_pkg::CFG_RADIUS:    sr_reg   <= cfg_wdata[30:0];
                    sdfa_pkg::CFG_REST:      rest_reg <= cfg_wdata[30:0];
                    sdfa_pkg::CFG_GAIN:      gain_reg <= cfg_wdata[30:0];
                    sdfa_pkg::CFG_DENS_COEF: coef_reg <= cfg_wdata[30:0];
                    sdfa_pkg::CFG_GRAD_COEF: gc_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.load) begin
                item_ov_reg <= 1'b0;
            end else if (step_done) begin
                case (cmd.op)
                    sdfa_pkg::OP_D1, sdfa_pkg::OP_D2, sdfa_pkg::OP_D3, sdfa_pkg::OP_F,
                    sdfa_pkg::OP_GM, sdfa_pkg::OP_P1, sdfa_pkg::OP_P2, sdfa_pkg::OP_M1,
                    sdfa_pkg::OP_M2: begin
                        item_ov_reg <= item_ov_reg || qov;
                    end
                    sdfa_pkg::OP_R1: begin
                        item_ov_reg <= item_ov_reg || (own_reg == 31'd0);
                    end
                    sdfa_pkg::OP_R2: begin
                        item_ov_reg <= item_ov_reg || (nb_reg == 31'd0);
                    end
                    sdfa_pkg::OP_DACC: begin
                        dens_reg <= dsum[31] ? sdfa_pkg::MASK31 : dsum[30:0];
                        if (item_ov_reg || t_big || dsum[31]) begin
                            sat_reg <= 1'b1;
                        end
                    end
                    sdfa_pkg::OP_FXACC: begin
                        fx_reg <= acc_clip;
                        if (item_ov_reg || acc_sat) begin
                            sat_reg <= 1'b1;
                        end
                    end
                    sdfa_pkg::OP_FYACC: begin
                        fy_reg <= acc_clip;
                        if (acc_sat) begin
                            sat_reg <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                dens_reg      <= 31'd0;
                fx_reg        <= 32'd0;
                fy_reg        <= 32'd0;
                sat_reg       <= 1'b0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
            xneg_reg <= s_tdata[31];
            yneg_reg <= s_tdata[63];
            ax_reg   <= s_tdata[31] ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
            ay_reg   <= s_tdata[63] ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32];
            own_reg  <= s_tdata[94:64];
            nb_reg   <= s_tdata[125:95];
        end else if (step_done) begin
            case (cmd.op)
                sdfa_pkg::OP_SQX:  r2_reg  <= mul_prod[63:0];
                sdfa_pkg::OP_SQY:  r2_reg  <= r2_reg + mul_prod[63:0];
                sdfa_pkg::OP_SQR:  sr2_reg <= mul_prod[63:0];
                sdfa_pkg::OP_D1, sdfa_pkg::OP_D2, sdfa_pkg::OP_D3: t_reg <= qval;
                sdfa_pkg::OP_ROOT: r_reg   <= sq_root;
                sdfa_pkg::OP_F:    f_reg   <= qval;
                sdfa_pkg::OP_GM:   gm_reg  <= qval;
                sdfa_pkg::OP_P1: begin
                    pm1_reg   <= qval;
                    p1neg_reg <= e1[31];
                end
                sdfa_pkg::OP_P2: begin
                    pm2_reg   <= qval;
                    p2neg_reg <= e2[31];
                end
                sdfa_pkg::OP_R1:   rec1_reg <= (own_reg == 31'd0) ? sdfa_pkg::LIMIT : div_quo;
                sdfa_pkg::OP_R2:   rec2_reg <= (nb_reg == 31'd0) ? sdfa_pkg::LIMIT : div_quo;
                sdfa_pkg::OP_M1:   m1_reg  <= qval;
                sdfa_pkg::OP_M2:   m2_reg  <= qval;
                sdfa_pkg::OP_UX, sdfa_pkg::OP_UY: u_reg <= div_quo;
                sdfa_pkg::OP_MX, sdfa_pkg::OP_MY: mag_reg <= item_ov_reg ? mag_ov : qval;
                default: begin
                end
            endcase
        end
        if (cmd.emit) begin
            dens_out_reg <= dens_reg;
            fx_out_reg   <= fx_reg;
            fy_out_reg   <= fy_reg;
            sat_out_reg  <= sat_reg;
        end
    end

    assign sts.done       = step_done;
    assign sts.kind       = kind_reg;
    assign sts.last       = last_reg;
    assign sts.dens_skip  = r2_reg >= sr2_reg;
    assign sts.force_skip = (r2_reg == 64'd0) || (r2_reg >= sr2_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, fy_out_reg, fx_out_reg, dens_out_reg};
    assign m_tuser  = sat_out_reg;
endmodule

### rtl/core/sdfa_ctrl.sv
// ============================================================================
// SPH accumulator - controller
// Accepts a pair, walks the datapath through its steps and, after the last pair, issues the result.
// ============================================================================
module sdfa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output sdfa_pkg::ctl_cmd_t cmd,
    input  sdfa_pkg::ctl_sts_t sts
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_NEXT  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    sdfa_pkg::op_t op_reg, op_next, op_follow;

    always_comb begin
        case (op_reg)
            sdfa_pkg::OP_SQX:   op_follow = sdfa_pkg::OP_SQY;
            sdfa_pkg::OP_SQY:   op_follow = sdfa_pkg::OP_SQR;
            sdfa_pkg::OP_SQR: begin
                if (sts.kind) begin
                    op_follow = sts.force_skip ? sdfa_pkg::OP_FIN : sdfa_pkg::OP_ROOT;
                end else begin
                    op_follow = sts.dens_skip ? sdfa_pkg::OP_FIN : sdfa_pkg::OP_D1;
                end
            end
            sdfa_pkg::OP_D1:    op_follow = sdfa_pkg::OP_D2;
            sdfa_pkg::OP_D2:    op_follow = sdfa_pkg::OP_D3;
            sdfa_pkg::OP_D3:    op_follow = sdfa_pkg::OP_DACC;
            sdfa_pkg::OP_ROOT:  op_follow = sdfa_pkg::OP_F;
            sdfa_pkg::OP_F:     op_follow = sdfa_pkg::OP_GM;
            sdfa_pkg::OP_GM:    op_follow = sdfa_pkg::OP_P1;
            sdfa_pkg::OP_P1:    op_follow = sdfa_pkg::OP_P2;
            sdfa_pkg::OP_P2:    op_follow = sdfa_pkg::OP_R1;
            sdfa_pkg::OP_R1:    op_follow = sdfa_pkg::OP_R2;
            sdfa_pkg::OP_R2:    op_follow = sdfa_pkg::OP_M1;
            sdfa_pkg::OP_M1:    op_follow = sdfa_pkg::OP_M2;
            sdfa_pkg::OP_M2:    op_follow = sdfa_pkg::OP_UX;
            sdfa_pkg::OP_UX:    op_follow = sdfa_pkg::OP_MX;
            sdfa_pkg::OP_MX:    op_follow = sdfa_pkg::OP_FXACC;
            sdfa_pkg::OP_FXACC: op_follow = sdfa_pkg::OP_UY;
            sdfa_pkg::OP_UY:    op_follow = sdfa_pkg::OP_MY;
            sdfa_pkg::OP_MY:    op_follow = sdfa_pkg::OP_FYACC;
            default:            op_follow = sdfa_pkg::OP_FIN;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.emit   = 1'b0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    op_next    = sdfa_pkg::OP_SQX;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (sts.done) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                op_next    = op_follow;
                state_next = (op_follow == sdfa_pkg::OP_FIN) ? S_EMIT : S_START;
            end
            S_EMIT: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= sdfa_pkg::OP_FIN;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free && sts.last)
        else $error("result issued while output register is occupied");
    a_load_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (op_reg == sdfa_pkg::OP_SQX) && (state_reg == S_START))
        else $error("accepted pair did not start with the first step");
    a_done_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT && sts.done) |=> state_reg == S_NEXT)
        else $error("step completion missed");
    a_start_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !s_tready && $stable(op_reg))
        else $error("step operation changed while a unit is busy");
`endif
endmodule

### rtl/core/sph_density_force_accumulator.sv
// A pair's processing time depends on its kind and on whether it lies inside the radius,
// and is set by the bit-serial divider (four quotients per force pair in range), the
// square root and the shared multiplier.
// Throughput: one pair at a time; the next pair is taken once the previous one is done.
// Reset: synchronous, active low; clears the sums, flag and output valid and loads
// the register defaults.
// ============================================================================
// SPH density and pressure force accumulator - top level
// Sums poly6 density or spiky pressure force over a particle's neighbor pairs.
// ============================================================================
module sph_density_force_accumulator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sdfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // offset_x, offset_y, own_density, neighbour_density, zero padding
    input  logic [127:0]                   s_tdata,
    // kind
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // density_sum, force_x, force_y, zero padding
    output logic [95:0]                    m_tdata,
    // saturated
    output logic                           m_tuser
);
    sdfa_pkg::ctl_cmd_t cmd;
    sdfa_pkg::ctl_sts_t sts;

    sdfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sdfa_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

### tb/sph_density_force_accumulator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// SPH density and pressure force accumulator - testbench
// Sends streams of neighbor pairs under several register settings and checks
// each emitted sum against a cycle-free predictor of the fixed-point math.
// Both stream sides idle at random, and the registers are rewritten only
// when the block has gone quiet.
// ============================================================================
module sph_density_force_accumulator_tb;

    localparam int  FRAC         = 16;
    localparam bit  KIND_DENSITY = 1'b0;
    localparam bit  KIND_FORCE   = 1'b1;
    localparam int  STALL_LIMIT  = 6000;
    localparam int  SETTLE       = 600;
    localparam longint unsigned CAP     = 64'h4000_0000_0000_0000;
    localparam longint unsigned MAX31   = 64'h7fff_ffff;
    localparam longint unsigned MIN_RAD = ((64'd1 << FRAC) + 64'd5) / 64'd10;

    typedef struct {
        bit               kind;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic [30:0]      own_rho;
        logic [30:0]      nb_rho;
        bit               last;
    } pair_t;

    typedef struct {
        logic [30:0] density;
        logic [31:0] fx;
        logic [31:0] fy;
        logic        sat;
    } sums_t;

    class sph_scoreboard;
        longint unsigned radius, rest, gain, dens_coef;
        longint          grad_coef;
        longint unsigned dens_acc;
        longint          fx_acc, fy_acc;
        bit              sat_seen;
        sums_t           expected_sums[$];
        int              errors;

        function new();
            radius    = 32768;
            rest      = 131072;
            gain      = 655360;
            dens_coef = 0;
            grad_coef = 0;
            dens_acc  = 0;
            fx_acc    = 0;
            fy_acc    = 0;
            sat_seen  = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [sdfa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                sdfa_pkg::CFG_RADIUS:    radius    = value[30:0];
                sdfa_pkg::CFG_REST:      rest      = value[30:0];
                sdfa_pkg::CFG_GAIN:      gain      = value[30:0];
                sdfa_pkg::CFG_DENS_COEF: dens_coef = value[30:0];
                sdfa_pkg::CFG_GRAD_COEF: grad_coef = longint'(signed'(value));
                default: ;
            endcase
        endfunction

        function longint unsigned fmul(longint unsigned a, longint unsigned b, inout bit ov);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> FRAC;
            if (p > {64'd0, CAP}) begin
                ov = 1;
                return CAP;
            end
            return p[63:0];
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   -= res + bitv;
                    res  = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned absval(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) begin
                sat_seen = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat_seen = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint pressure_of(longint unsigned rho, inout bit ov);
            longint e, m;
            e = longint'(rho) - longint'(rest);
            m = longint'(fmul(absval(e), gain, ov));
            return e < 0 ? -m : m;
        endfunction

        function longint unsigned inv_rho(longint unsigned rho, inout bit ov);
            if (rho == 0) begin
                ov = 1;
                return CAP;
            end
            return (64'd1 << (2 * FRAC)) / rho;
        endfunction

        function void add_density(longint unsigned r2);
            longint unsigned sr, sr2, d, t;
            bit ov;
            ov = 0;
            sr = radius < MIN_RAD ? MIN_RAD : radius;
            sr2 = sr * sr;
            if (r2 >= sr2) return;
            d = (sr2 - r2) >> FRAC;
            t = fmul(dens_coef, d, ov);
            t = fmul(t, d, ov);
            t = fmul(t, d, ov);
            if (ov || t > MAX31) begin
                sat_seen = 1;
                t = MAX31;
            end
            dens_acc += t;
            if (dens_acc > MAX31) begin
                sat_seen = 1;
                dens_acc = MAX31;
            end
        endfunction

        function void add_force(longint dx, longint dy, longint unsigned r2,
                                longint unsigned own, longint unsigned nb);
            longint unsigned r, s, f, gm, shm, rsum, m1, m2, u, mag;
            longint sum, val, comp;
            int ssign, gsign, vsign;
            bit ov, ov2;
            ov = 0;
            if (r2 == 0 || r2 >= radius * radius) return;
            r     = root(r2);
            s     = radius - r;
            f     = fmul(s, s, ov);
            gm    = fmul(absval(grad_coef), f, ov);
            gsign = grad_coef < 0 ? -1 : 1;
            sum   = pressure_of(own, ov) + pressure_of(nb, ov);
            ssign = sum < 0 ? -1 : 1;
            shm   = absval(sum) >> 1;
            rsum  = inv_rho(own, ov) + inv_rho(nb, ov);
            m1    = fmul(shm, rsum, ov);
            m2    = fmul(m1, gm, ov);
            if (ov) sat_seen = 1;
            for (int k = 0; k < 2; k++) begin
                comp  = k ? dy : dx;
                u     = (absval(comp) << FRAC) / r;
                ov2   = 0;
                if (ov) mag = (shm != 0 && gm != 0 && u != 0) ? (64'd1 << 31) : 0;
                else    mag = fmul(m2, u, ov2);
                val   = longint'(mag);
                vsign = comp < 0 ? -1 : 1;
                if (-ssign * gsign * vsign < 0) val = -val;
                if (k) fy_acc = clip(fy_acc + val);
                else   fx_acc = clip(fx_acc + val);
            end
        endfunction

        function void note_request(pair_t p);
            longint dx, dy;
            longint unsigned r2;
            sums_t res;
            dx = longint'(p.off_x);
            dy = longint'(p.off_y);
            r2 = absval(dx) * absval(dx) + absval(dy) * absval(dy);
            if (p.kind == KIND_DENSITY) add_density(r2);
            else add_force(dx, dy, r2, p.own_rho, p.nb_rho);
            if (!p.last) return;
            res.density = dens_acc[30:0];
            res.fx      = fx_acc[31:0];
            res.fy      = fy_acc[31:0];
            res.sat     = sat_seen;
            expected_sums.insert(expected_sums.size(), res);
            dens_acc = 0;
            fx_acc   = 0;
            fy_acc   = 0;
            sat_seen = 0;
        endfunction

        function void check_result(logic [95:0] data, logic flag);
            sums_t e;
            if (expected_sums.size() == 0) begin
                $error("unexpected result: no request pending");
                errors++;
                return;
            end
            e = expected_sums.pop_front();
            if (data[30:0] !== e.density) begin
                $error("density_sum: expected %0d, actual %0d", e.density, data[30:0]);
                errors++;
            end
            if (data[62:31] !== e.fx) begin
                $error("force_x: expected %0d, actual %0d",
                       $signed(e.fx), $signed(data[62:31]));
                errors++;
            end
            if (data[94:63] !== e.fy) begin
                $error("force_y: expected %0d, actual %0d",
                       $signed(e.fy), $signed(data[94:63]));
                errors++;
            end
            if (flag !== e.sat) begin
                $error("saturated: expected %0d, actual %0d", e.sat, flag);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [sdfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [127:0]                   s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [95:0]                    m_tdata;
    logic                           m_tuser;

    sph_scoreboard sb = new();
    bit calm;
    int idle_count;

    always #6 aclk = ~aclk;

    sph_density_force_accumulator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int gap_len();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] near_offset(longint unsigned span);
        logic signed [31:0] v;
        longint unsigned lim;
        lim = span > 64'h7fff_ffff ? 64'h7fff_ffff : span;
        v = lim == 0 ? 32'sd0 : $signed(32'($urandom_range(0, 32'(lim))));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [30:0] pick_density();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 25) return 31'($urandom());
        return 31'($urandom_range(0, 4 * 65536)) + 31'd1;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        p.kind    = $urandom_range(0, 1);
        p.own_rho = pick_density();
        p.nb_rho  = pick_density();
        p.last    = $urandom_range(0, 5) == 0;
        if ($urandom_range(0, 99) < 15) begin
            p.off_x = $urandom();
            p.off_y = $urandom();
        end else begin
            p.off_x = near_offset(sb.radius * 3 / 4);
            p.off_y = near_offset(sb.radius * 3 / 4);
        end
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata  = {2'b00, p.nb_rho, p.own_rho, p.off_y, p.off_x};
        s_tuser  = p.kind;
        s_tlast  = p.last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(p);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [sdfa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic setup(logic [31:0] rad, logic [31:0] rst, logic [31:0] gn,
                         logic [31:0] dc, logic [31:0] gc);
        write_reg(sdfa_pkg::CFG_RADIUS, rad);
        write_reg(sdfa_pkg::CFG_REST, rst);
        write_reg(sdfa_pkg::CFG_GAIN, gn);
        write_reg(sdfa_pkg::CFG_DENS_COEF, dc);
        write_reg(sdfa_pkg::CFG_GRAD_COEF, gc);
    endtask

    task automatic directed_pair(bit kind, logic [31:0] x, logic [31:0] y,
                                 logic [30:0] own, logic [30:0] nb, bit last);
        pair_t p;
        p.kind    = kind;
        p.off_x   = x;
        p.off_y   = y;
        p.own_rho = own;
        p.nb_rho  = nb;
        p.last    = last;
        send_pair(p);
    endtask

    task automatic random_phase(int count);
        pair_t p;
        calm = $urandom_range(0, 3) == 0;
        for (int i = 0; i < count; i++) begin
            p = random_pair();
            if (i == count - 1) p.last = 1;
            send_pair(p);
        end
        calm = 0;
        drain();
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                stall = gap_len();
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        idle_count = 0;
        calm = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Register defaults: both coefficients are zero, so neither density nor force terms move.
        directed_pair(KIND_DENSITY, 32'd0, 32'd0, 31'd0, 31'd0, 1'b1);
        directed_pair(KIND_FORCE, 32'd8000, 32'hffff_e000, 31'd150000, 31'd90000, 1'b1);
        drain();

        setup(32'd32768, 32'd131072, 32'd655360, 32'd21361664, 32'hfecf_6c00);
        directed_pair(KIND_DENSITY, 32'd0, 32'd0, 31'd0, 31'd0, 1'b0);
        directed_pair(KIND_DENSITY, 32'd10000, 32'hffff_c000, 31'd0, 31'd0, 1'b0);
        directed_pair(KIND_DENSITY, 32'd40000, 32'd0, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1);
        directed_pair(KIND_DENSITY, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 1'b1);
        directed_pair(KIND_DENSITY, 32'h7fff_ffff, 32'h7fff_ffff, 31'd5, 31'd5, 1'b1);
        directed_pair(KIND_FORCE, 32'd0, 32'd0, 31'd200000, 31'd200000, 1'b1);
        directed_pair(KIND_FORCE, 32'd12000, 32'd3000, 31'd0, 31'd100000, 1'b1);
        directed_pair(KIND_FORCE, 32'hffff_d000, 32'd9000, 31'd140000, 31'd0, 1'b1);
        directed_pair(KIND_FORCE, 32'd5000, 32'hffff_f000, 31'd180000, 31'd70000, 1'b0);
        directed_pair(KIND_FORCE, 32'hffff_f000, 32'd0, 31'd131072, 31'd131072, 1'b0);
        directed_pair(KIND_DENSITY, 32'd2000, 32'd2000, 31'd0, 31'd0, 1'b1);
        directed_pair(KIND_FORCE, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 31'd1, 1'b1);
        drain();

        // Radius zero: density uses the minimum radius, force takes no pair.
        setup(32'd0, 32'd131072, 32'd655360, 32'h7fff_ffff, 32'h8000_0000);
        directed_pair(KIND_DENSITY, 32'd0, 32'd0, 31'd0, 31'd0, 1'b0);
        directed_pair(KIND_DENSITY, 32'd3000, 32'd3000, 31'd0, 31'd0, 1'b1);
        directed_pair(KIND_FORCE, 32'd1, 32'd0, 31'd1000, 31'd1000, 1'b1);
        drain();

        // Largest radius and coefficients drive both pairs into saturation.
        setup(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        directed_pair(KIND_DENSITY, 32'd1, 32'd1, 31'd0, 31'd0, 1'b1);
        directed_pair(KIND_FORCE, 32'h4000_0000, 32'hc000_0000, 31'd1, 31'd7, 1'b1);
        drain();

        random_phase(60);

        setup(32'd32768, 32'd131072, 32'd655360, 32'd21361664, 32'hfecf_6c00);
        random_phase(300);

        setup(32'd65536, 32'd0, 32'd0, 32'd1000, 32'd0);
        random_phase(80);

        setup(32'd16384, 32'd65536, 32'd200000, 32'd5000000, 32'hf000_0000);
        random_phase(200);

        setup({1'b1, 31'd200000}, {1'b1, 31'd131072}, {1'b1, 31'd40000},
              {1'b1, 31'd300}, 32'hffff_0000);
        random_phase(150);

        setup(32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_0000);
        random_phase(40);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sph_density_force_accumulator.f
rtl/core/sdfa_pkg.sv
rtl/core/sdfa_mul.sv
rtl/core/sdfa_div.sv
rtl/core/sdfa_sqrt.sv
rtl/core/sdfa_datapath.sv
rtl/core/sdfa_ctrl.sv
rtl/core/sph_density_force_accumulator.sv
tb/sph_density_force_accumulator_tb.sv
